// File: src/binary_heap_priority_queue_defines.svh
// Assertion macros for the binary heap priority queue checker.
// No dependencies; included by the checker file.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define BHPQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bhpq assertion failed");

// Next-cycle implication, disabled in reset.
`define BHPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bhpq assertion failed");

`endif

// File: src/bhpq_pkg.sv
// Shared constants, types and compare function for the binary heap priority queue.
// No dependencies; used by bhpq_cell and binary_heap_priority_queue.
package bhpq_pkg;

   localparam int CAPACITY = 1024;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int FILL_W   = 11;
   localparam int VAL_W    = 32;
   localparam int STAT_W   = 2;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      REQ_INSERT  = 1'b0,
      REQ_EXTRACT = 1'b1
   } req_kind_type;

   // Broadcast control seen by every cell in the same cycle.
   typedef struct packed {
      logic                    ins;
      logic                    ext;
      logic                    order_max;
      logic signed [VAL_W-1:0] x;
   } cell_ctl_type;

   // True when a must sit closer to the head than b.
   function automatic logic ahead(input logic signed [VAL_W-1:0] a,
                                  input logic signed [VAL_W-1:0] b,
                                  input logic order_max);
      ahead = order_max ? (a > b) : (a < b);
   endfunction

endpackage

// File: src/bhpq_cell.sv
// One slot of the sorted chain: holds a value and its valid flag.
// Depends on bhpq_pkg.
module bhpq_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  bhpq_pkg::cell_ctl_type              ctl,
   input  logic                                prev_keep,
   input  logic                                prev_valid,
   input  logic signed [bhpq_pkg::VAL_W-1:0]   prev_value,
   input  logic                                next_valid,
   input  logic signed [bhpq_pkg::VAL_W-1:0]   next_value,
   output logic                                keep,
   output logic                                valid,
   output logic signed [bhpq_pkg::VAL_W-1:0]   value
);

   logic                              valid_ff, valid_in;
   logic signed [bhpq_pkg::VAL_W-1:0] value_ff, value_in;

   // Hold the slot when it stays ahead of the new value.
   assign keep = valid_ff && !bhpq_pkg::ahead(ctl.x, value_ff, ctl.order_max);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctl.ins) begin
         valid_in = valid_ff || prev_valid;
         if (!keep) begin
            // first slot past the kept run takes the new value, the rest shift back
            value_in = prev_keep ? ctl.x : prev_value;
         end
      end else if (ctl.ext) begin
         // advance toward the head
         valid_in = next_valid;
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;

endmodule

// File: src/binary_heap_priority_queue.sv
// Top level of the priority queue: a sorted chain of cells, head is the root.
// Depends on bhpq_pkg and bhpq_cell.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | tuser: req_type; tdata: value
//   rsp     | out | rsp_tvalid/rsp_tready | tuser: status; tdata: out_value, fill
//   csr     | in  | csr_wen               | csr_wdata: order_max (bit 0)
//
// For each request all cells compare against the broadcast value and shift in
// parallel; the response is registered and appears in the cycle after acceptance.
// Reset empties the chain and selects min order; no clearing pass is needed.
// A waiting response holds req_tready low only while rsp_tready is low.
// An order write is taken only while the queue is empty.
module binary_heap_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,   // [0] req_type
   input  logic [31:0] req_tdata,   // [31:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic [47:0] rsp_tdata,   // [31:0] out_value, [42:32] fill, [47:43] zero
   input  logic        csr_wen,
   input  logic        csr_wdata
);

   localparam int N = bhpq_pkg::CAPACITY;

   logic [bhpq_pkg::CNT_W-1:0]          count_ff, count_in;
   logic                                order_ff;
   logic                                rsp_valid_ff;
   logic signed [bhpq_pkg::VAL_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [bhpq_pkg::STAT_W-1:0]         rsp_stat_ff, rsp_stat_in;
   logic [bhpq_pkg::FILL_W-1:0]         rsp_fill_ff;
   logic                                accept, is_ext, full, empty;
   bhpq_pkg::cell_ctl_type              ctl;

   logic                                keep_c  [N];
   logic                                valid_c [N];
   logic signed [bhpq_pkg::VAL_W-1:0]   value_c [N];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_ext     = (req_tuser[0] == bhpq_pkg::REQ_EXTRACT);
   assign full       = (count_ff == bhpq_pkg::CNT_W'(N));
   assign empty      = (count_ff == '0);

   assign ctl.ins       = accept && !is_ext && !full;
   assign ctl.ext       = accept && is_ext && !empty;
   assign ctl.order_max = order_ff;
   assign ctl.x         = req_tdata;

   genvar gi;
   generate
      for (gi = 0; gi < N; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            bhpq_cell u_cell (
               .clock, .reset, .ctl,
               .prev_keep  (1'b1),
               .prev_valid (1'b1),
               .prev_value ('0),
               .next_valid (valid_c[gi+1]),
               .next_value (value_c[gi+1]),
               .keep       (keep_c[gi]),
               .valid      (valid_c[gi]),
               .value      (value_c[gi])
            );
         end else if (gi == N - 1) begin : g_tail
            bhpq_cell u_cell (
               .clock, .reset, .ctl,
               .prev_keep  (keep_c[gi-1]),
               .prev_valid (valid_c[gi-1]),
               .prev_value (value_c[gi-1]),
               .next_valid (1'b0),
               .next_value ('0),
               .keep       (keep_c[gi]),
               .valid      (valid_c[gi]),
               .value      (value_c[gi])
            );
         end else begin : g_mid
            bhpq_cell u_cell (
               .clock, .reset, .ctl,
               .prev_keep  (keep_c[gi-1]),
               .prev_valid (valid_c[gi-1]),
               .prev_value (value_c[gi-1]),
               .next_valid (valid_c[gi+1]),
               .next_value (value_c[gi+1]),
               .keep       (keep_c[gi]),
               .valid      (valid_c[gi]),
               .value      (value_c[gi])
            );
         end
      end
   endgenerate

   always_comb begin
      count_in     = count_ff;
      rsp_value_in = '0;
      rsp_stat_in  = bhpq_pkg::STAT_OK;
      if (is_ext) begin
         if (empty) begin
            rsp_stat_in = bhpq_pkg::STAT_EMPTY;
         end else begin
            rsp_value_in = value_c[0];
            count_in     = count_ff - 1'b1;
         end
      end else begin
         if (full) begin
            rsp_stat_in = bhpq_pkg::STAT_FULL;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         order_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         // drop order writes while entries are stored
         if (csr_wen && empty) begin
            order_ff <= csr_wdata;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         rsp_value_ff <= rsp_value_in;
         rsp_stat_ff  <= rsp_stat_in;
         rsp_fill_ff  <= bhpq_pkg::FILL_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tdata  = {5'd0, rsp_fill_ff, rsp_value_ff};

endmodule

// File: src/bhpq_checker.sv
// Port-level checker for the binary heap priority queue, bound to the top level.
// Depends on bhpq_pkg and binary_heap_priority_queue_defines.svh.
`include "binary_heap_priority_queue_defines.svh"

module bhpq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [0:0]  req_tuser,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [1:0]  rsp_tuser,
   input logic [47:0] rsp_tdata
);

   logic req_take;
   logic rsp_empty, rsp_full;
   assign req_take  = req_tvalid && req_tready;
   assign rsp_empty = rsp_tvalid && (rsp_tuser == bhpq_pkg::STAT_EMPTY);
   assign rsp_full  = rsp_tvalid && (rsp_tuser == bhpq_pkg::STAT_FULL);

   `BHPQ_ASSERT_NEXT(a_rsp_follows, clock, reset, req_take, rsp_tvalid)
   `BHPQ_ASSERT_NOW(a_empty_zero, clock, reset, rsp_empty, rsp_tdata == 48'd0)
   `BHPQ_ASSERT_NOW(a_full_fill, clock, reset, rsp_full, rsp_tdata == 48'h400_0000_0000)
   `BHPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

endmodule

bind binary_heap_priority_queue bhpq_checker u_bhpq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

// File: verif/tb.sv
// Testbench for binary_heap_priority_queue: directed table, then random insert/extract mixes.
// Depends on bhpq_pkg; the priority order is predicted by a behavioral heap kept in this module.
`timescale 1ns / 100ps

module tb;

   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic signed [31:0]   value;
      bhpq_pkg::status_type status;
      logic [10:0]          fill;
   } heap_result_type;

   typedef struct packed {
      bhpq_pkg::req_kind_type kind;
      logic signed [31:0]     value;
      logic                   typed;   // expected result typed in below
      heap_result_type        result;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [0:0]  req_tuser = '0;    // [0] req_type
   logic [31:0] req_tdata = '0;    // [31:0] value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [1:0]  rsp_tuser;         // [1:0] status
   logic [47:0] rsp_tdata;         // [31:0] out_value, [42:32] fill
   logic        csr_wen = 1'b0;
   logic        csr_wdata = 1'b0;

   // behavioral heap
   logic signed [31:0] heap_vals [bhpq_pkg::CAPACITY];
   int                 heap_count = 0;
   logic               order_is_max = 1'b0;

   heap_result_type pending_results[$];
   int              errors = 0;
   int              cycles = 0;
   bit              calm = 1'b0;      // stretch with no idling on either side
   int              stall_left = 0;

   directed_row_type directed_rows [16];

   binary_heap_priority_queue i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic bit outranks(logic signed [31:0] a, logic signed [31:0] b);
      return order_is_max ? (a > b) : (a < b);
   endfunction

   function automatic heap_result_type heap_apply(bhpq_pkg::req_kind_type kind,
                                                  logic signed [31:0] val);
      heap_result_type res;
      int pos, up, left, pick;
      logic signed [31:0] tmp;
      res = '{value: '0, status: bhpq_pkg::STAT_OK, fill: '0};
      if (kind == bhpq_pkg::REQ_INSERT) begin
         if (heap_count >= bhpq_pkg::CAPACITY) begin
            res.status = bhpq_pkg::STAT_FULL;
         end else begin
            pos = heap_count;
            heap_vals[pos] = val;
            heap_count++;
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (!outranks(heap_vals[pos], heap_vals[up])) break;
               tmp = heap_vals[pos]; heap_vals[pos] = heap_vals[up]; heap_vals[up] = tmp;
               pos = up;
            end
         end
      end else begin
         if (heap_count == 0) begin
            res.status = bhpq_pkg::STAT_EMPTY;
         end else begin
            res.value = heap_vals[0];
            heap_count--;
            heap_vals[0] = heap_vals[heap_count];
            pos = 0;
            forever begin
               left = 2 * pos + 1;
               if (left >= heap_count) break;
               pick = left;
               if (left + 1 < heap_count && outranks(heap_vals[left + 1], heap_vals[left]))
                  pick = left + 1;
               if (!outranks(heap_vals[pick], heap_vals[pos])) break;
               tmp = heap_vals[pos]; heap_vals[pos] = heap_vals[pick]; heap_vals[pick] = tmp;
               pos = pick;
            end
         end
      end
      res.fill = heap_count[10:0];
      return res;
   endfunction

   function automatic int gap_length();
      int r;
      r = $urandom_range(99);
      if (calm || r < 50) return 0;
      if (r < 90) return $urandom_range(3, 1);
      if (r < 98) return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic logic signed [31:0] random_value(bit narrow);
      int r;
      r = $urandom_range(15);
      if (narrow || r < 4) return $signed($urandom_range(8)) - 4;
      if (r == 4) return 32'sh8000_0000;
      if (r == 5) return 32'sh7fff_ffff;
      return $urandom;
   endfunction

   // Drive one request, hold it until accepted, then record its expected response.
   task automatic send_request(bhpq_pkg::req_kind_type kind, logic signed [31:0] val,
                               bit typed = 0, heap_result_type typed_res = '0);
      int gap;
      heap_result_type res;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= val;
      do @(posedge clock); while (!req_tready);
      res = heap_apply(kind, val);
      pending_results.push_back(typed ? typed_res : res);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_order(logic order);
      csr_wen   <= 1'b1;
      csr_wdata <= order;
      @(posedge clock);
      csr_wen   <= 1'b0;
      if (heap_count == 0) order_is_max = order;
   endtask

   task automatic run_mix(int n, int insert_pct, bit narrow);
      repeat (n) begin
         if ($urandom_range(99) < insert_pct)
            send_request(bhpq_pkg::REQ_INSERT, random_value(narrow));
         else
            send_request(bhpq_pkg::REQ_EXTRACT, $urandom);
      end
   endtask

   task automatic drain_heap();
      while (heap_count > 0) send_request(bhpq_pkg::REQ_EXTRACT, $urandom);
      send_request(bhpq_pkg::REQ_EXTRACT, $urandom);
   endtask

   // response check and random back-pressure
   always @(posedge clock) begin
      heap_result_type exp_res;
      cycles <= cycles + 1;
      if (cycles % 300 == 299) calm <= ($urandom_range(3) == 0);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response status=%0d value=%0d fill=%0d", $time,
                     rsp_tuser, $signed(rsp_tdata[31:0]), rsp_tdata[42:32]);
            errors++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_tuser != exp_res.status) begin
               $display("%0t: status expected %0d actual %0d", $time, exp_res.status, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[31:0] != exp_res.value) begin
               $display("%0t: out_value expected %0d actual %0d", $time, exp_res.value,
                        $signed(rsp_tdata[31:0]));
               errors++;
            end
            if (rsp_tdata[42:32] != exp_res.fill) begin
               $display("%0t: fill expected %0d actual %0d", $time, exp_res.fill,
                        rsp_tdata[42:32]);
               errors++;
            end
         end
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm && $urandom_range(99) < 30) stall_left <= gap_length();
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      directed_rows = '{
         '{bhpq_pkg::REQ_EXTRACT, 32'sd0,         1'b1,
           '{32'sd0,         bhpq_pkg::STAT_EMPTY, 11'd0}},
         '{bhpq_pkg::REQ_INSERT,  32'sh7fff_ffff, 1'b1,
           '{32'sd0,         bhpq_pkg::STAT_OK,    11'd1}},
         '{bhpq_pkg::REQ_INSERT,  32'sh8000_0000, 1'b1,
           '{32'sd0,         bhpq_pkg::STAT_OK,    11'd2}},
         '{bhpq_pkg::REQ_INSERT,  32'sd0,         1'b1,
           '{32'sd0,         bhpq_pkg::STAT_OK,    11'd3}},
         '{bhpq_pkg::REQ_INSERT,  -32'sd1,        1'b1,
           '{32'sd0,         bhpq_pkg::STAT_OK,    11'd4}},
         '{bhpq_pkg::REQ_INSERT,  32'sd5,         1'b1,
           '{32'sd0,         bhpq_pkg::STAT_OK,    11'd5}},
         '{bhpq_pkg::REQ_INSERT,  32'sd5,         1'b1,
           '{32'sd0,         bhpq_pkg::STAT_OK,    11'd6}},
         '{bhpq_pkg::REQ_EXTRACT, 32'sh5555_aaaa, 1'b1,
           '{32'sh8000_0000, bhpq_pkg::STAT_OK,    11'd5}},
         '{bhpq_pkg::REQ_EXTRACT, 32'sd0,         1'b1,
           '{-32'sd1,        bhpq_pkg::STAT_OK,    11'd4}},
         '{bhpq_pkg::REQ_INSERT,  32'sd3,         1'b0, '0},
         '{bhpq_pkg::REQ_EXTRACT, 32'sd0,         1'b0, '0},
         '{bhpq_pkg::REQ_EXTRACT, 32'sd0,         1'b0, '0},
         '{bhpq_pkg::REQ_EXTRACT, 32'sd0,         1'b0, '0},
         '{bhpq_pkg::REQ_EXTRACT, 32'sd0,         1'b0, '0},
         '{bhpq_pkg::REQ_EXTRACT, 32'sd0,         1'b1,
           '{32'sh7fff_ffff, bhpq_pkg::STAT_OK,    11'd0}},
         '{bhpq_pkg::REQ_EXTRACT, 32'shffff_ffff, 1'b1,
           '{32'sd0,         bhpq_pkg::STAT_EMPTY, 11'd0}}
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_order(1'b0);

      foreach (directed_rows[i])
         send_request(directed_rows[i].kind, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].result);
      run_mix(40, 55, 1'b0);
      drain_heap();

      // max order: a short mix with many ties, then fill to capacity
      wait_idle();
      write_order(1'b1);
      run_mix(30, 60, 1'b1);
      while (heap_count < bhpq_pkg::CAPACITY)
         send_request(bhpq_pkg::REQ_INSERT, random_value($urandom_range(3) == 0));
      repeat (4) send_request(bhpq_pkg::REQ_INSERT, random_value(1'b0));
      wait_idle();
      write_order(1'b0);   // heap not empty: order must stay max
      run_mix(20, 50, 1'b0);

      wait_idle();
      repeat (10) @(posedge clock);
      if (errors == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

endmodule
